/* rtl/ffa_pkg.sv */
// Package for the first-fit allocator: operation and status codes, engine states.
// No dependencies.
package ffa_pkg;

    typedef enum logic {
        FUNC_ALLOC   = 1'b0,
        FUNC_RELEASE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_WAIT,
        S_SHIFT_UP,
        S_SHIFT_UP_WR,
        S_SPLIT_WR,
        S_REL_NEXT,
        S_REL_PREV,
        S_SHIFT_DN,
        S_SHIFT_DN_WR,
        S_DONE
    } state_t;

endpackage

/* rtl/ffa_seg_ram.sv */
// Segment table memory: one write port, one registered read port.
// Depends on nothing; entry layout is decided by the top level.
module ffa_seg_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 40
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/first_fit_allocator.sv */
// First-fit allocator with coalescing: one segment table memory, scanned and
// shifted by a sequencer. Depends on ffa_pkg and ffa_seg_ram.
// Sequence: after the input transfer, the entries are scanned in order, then entries
//   are moved on a split or merge.
// Throughput: one request at a time; the output register frees the sequencer, so a
//   stalled result holds back only the next result. Entry 0 reads as one free segment
//   until first written, so no clearing pass is needed; aresetn clears control state.
module first_fit_allocator #(
    parameter int MEMORY_BYTES = 16384,
    parameter int HEADER_BYTES = 16,
    parameter int MAX_SEGMENTS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] task_id, [21:8] request_length, [23:22] zero
    input  logic [23:0] s_tdata,
    // [0] func
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [15:2] data_offset, [29:16] granted_length, [31:30] zero
    output logic [31:0] m_tdata
);
    import ffa_pkg::*;

    localparam int AW  = $clog2(MAX_SEGMENTS);
    localparam int CW  = $clog2(MAX_SEGMENTS + 1);
    localparam int LW  = $clog2(MEMORY_BYTES + 1) + 1;
    localparam int EW  = 2 * LW + 1 + 8;
    localparam logic [LW-1:0] HDR = LW'(HEADER_BYTES);

    // Entry: {owner, free, length, start}
    typedef struct packed {
        logic [7:0]    owner;
        logic          free;
        logic [LW-1:0] length;
        logic [LW-1:0] start;
    } entry_t;

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;   // scan / shift pointer
    logic [CW-1:0] hit_reg, hit_next;   // found entry
    logic          func_reg;
    logic [7:0]    task_reg;
    logic [LW-1:0] want_reg;
    entry_t        cur_reg, cur_next;    // found entry (being modified)
    entry_t        tmp_reg, tmp_next;    // new free entry of a split
    logic [1:0]    drop_reg, drop_next;  // entries removed by a merge
    logic          merged_reg, merged_next; // next neighbor merged
    logic          init_reg;             // entry 0 not yet written since reset
    logic [1:0]    st_reg, st_next;
    logic [13:0]   off_reg, off_next, len_reg, len_next;
    logic          m_valid_reg;
    logic [31:0]   m_data_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata, rword, rd;
    logic          rd_zero_reg;          // last read was entry 0

    ffa_seg_ram #(.DEPTH(MAX_SEGMENTS), .WIDTH(EW)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rword)
    );

    // Entry 0 reads as its reset value until first written.
    always_comb begin
        rd = rword;
        if (init_reg && rd_zero_reg) begin
            rd.owner  = '0;
            rd.free   = 1'b1;
            rd.length = LW'(MEMORY_BYTES - HEADER_BYTES);
            rd.start  = '0;
        end
    end

    // Take a request only in idle; the result waits in its own register.
    logic accept;
    logic out_free;
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    logic fit;
    logic [LW-1:0] spare;
    always_comb begin
        spare = rd.length - want_reg;
        if (func_reg == FUNC_ALLOC) begin
            fit = rd.free && (rd.length >= want_reg);
        end else begin
            fit = !rd.free && (rd.owner == task_reg);
        end
    end

    // Release merge bookkeeping, valid while rd holds the previous entry.
    logic          rel_prev_free;
    logic [1:0]    rel_nrem;
    logic [CW-1:0] rel_first, rel_count;
    assign rel_prev_free = (hit_reg != '0) && rd.free;
    assign rel_nrem      = 2'(merged_reg) + 2'(rel_prev_free);
    assign rel_first     = rel_prev_free ? hit_reg : hit_reg + CW'(1);
    assign rel_count     = count_reg - CW'(rel_nrem);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (accept) state_next = S_SCAN;
            S_SCAN:      state_next = (idx_reg < count_reg) ? S_SCAN_WAIT : S_DONE;
            S_SCAN_WAIT: begin
                if (!fit) begin
                    state_next = S_SCAN;
                end else if (func_reg == FUNC_ALLOC) begin
                    if (spare >= HDR) begin
                        state_next = (count_reg >= CW'(MAX_SEGMENTS)) ? S_DONE
                                   : (count_reg > idx_reg + CW'(1)) ? S_SHIFT_UP
                                   : S_SPLIT_WR;
                    end else begin
                        state_next = S_DONE;
                    end
                end else begin
                    state_next = (idx_reg + CW'(1) < count_reg) ? S_REL_NEXT : S_REL_PREV;
                end
            end
            S_SHIFT_UP:    state_next = S_SHIFT_UP_WR;
            S_SHIFT_UP_WR: state_next = (idx_reg == hit_reg + CW'(2)) ? S_SPLIT_WR : S_SHIFT_UP;
            S_SPLIT_WR:    state_next = S_DONE;
            S_REL_NEXT:    state_next = S_REL_PREV;
            S_REL_PREV: begin
                state_next = (rel_nrem != 2'd0 && rel_first < rel_count) ? S_SHIFT_DN
                                                                          : S_DONE;
            end
            S_SHIFT_DN:    state_next = S_SHIFT_DN_WR;
            S_SHIFT_DN_WR: state_next = (idx_reg + CW'(1) < count_reg) ? S_SHIFT_DN : S_DONE;
            S_DONE:        state_next = out_free ? S_IDLE : S_DONE;
            default:       state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        count_next  = count_reg;
        cur_next    = cur_reg;
        tmp_next    = tmp_reg;
        drop_next   = drop_reg;
        st_next     = st_reg;
        off_next    = off_reg;
        len_next    = len_reg;
        merged_next = merged_reg;
        we    = 1'b0;
        waddr = hit_reg[AW-1:0];
        wdata = cur_reg;
        raddr = idx_reg[AW-1:0];
        case (state_reg)
            S_IDLE: begin
                idx_next = '0;
                merged_next = 1'b0;
            end
            S_SCAN: begin
                raddr = idx_reg[AW-1:0];
                if (idx_reg >= count_reg) begin
                    st_next  = (func_reg == FUNC_ALLOC) ? ST_NO_FIT : ST_NOT_FOUND;
                    off_next = '0;
                    len_next = '0;
                end
            end
            S_SCAN_WAIT: begin
                hit_next = idx_reg;
                cur_next = rd;
                idx_next = idx_reg + CW'(1);
                if (fit && func_reg == FUNC_ALLOC) begin
                    st_next  = ST_OK;
                    off_next = 14'(rd.start + HDR);
                    len_next = 14'(rd.length);
                    cur_next.free  = 1'b0;
                    cur_next.owner = task_reg;
                    if (spare >= HDR) begin
                        if (count_reg >= CW'(MAX_SEGMENTS)) begin
                            st_next  = ST_NO_FIT;
                            off_next = '0;
                            len_next = '0;
                        end else begin
                            cur_next.length = want_reg;
                            len_next = 14'(want_reg);
                            tmp_next.start  = rd.start + HDR + want_reg;
                            tmp_next.length = spare - HDR;
                            tmp_next.free   = 1'b1;
                            tmp_next.owner  = '0;
                            idx_next = count_reg;  // top of the move-up
                        end
                    end
                    if (!(spare >= HDR)) begin
                        we = 1'b1;
                        waddr = idx_reg[AW-1:0];
                        wdata = cur_next;
                    end
                end else if (fit) begin
                    st_next  = ST_OK;
                    off_next = 14'(rd.start + HDR);
                    cur_next.free  = 1'b1;
                    cur_next.owner = '0;
                    // Fetch the next entry, or the previous one when there is no next.
                    raddr = (idx_reg + CW'(1) < count_reg) ? AW'(idx_reg + CW'(1))
                                                          : AW'(idx_reg - CW'(1));
                end
            end
            // Move entry idx-1 to idx, from the top down to hit+2.
            S_SHIFT_UP: raddr = AW'(idx_reg - CW'(1));
            S_SHIFT_UP_WR: begin
                we    = 1'b1;
                waddr = idx_reg[AW-1:0];
                wdata = rd;
                idx_next = idx_reg - CW'(1);
            end
            S_SPLIT_WR: begin
                // Write the new free entry; the granted entry goes in S_DONE.
                we    = 1'b1;
                waddr = AW'(hit_reg + CW'(1));
                wdata = tmp_reg;
                count_next = count_reg + CW'(1);
            end
            S_REL_NEXT: begin
                // rd holds entry hit+1
                if (rd.free) begin
                    cur_next.length = cur_reg.length + HDR + rd.length;
                    merged_next = 1'b1;
                end
                raddr = AW'(hit_reg - CW'(1));
            end
            S_REL_PREV: begin
                // rd holds entry hit-1; fold the freed entry into it when free.
                if (rel_prev_free) begin
                    cur_next = rd;
                    cur_next.length = rd.length + HDR + cur_reg.length;
                    hit_next = hit_reg - CW'(1);
                end
                we    = 1'b1;
                waddr = rel_prev_free ? AW'(hit_reg - CW'(1)) : hit_reg[AW-1:0];
                wdata = cur_next;
                len_next   = 14'(cur_next.length);
                count_next = rel_count;
                idx_next   = rel_first;  // first slot to refill
                drop_next  = rel_nrem;
            end
            // Move entry idx+drop to idx until the new count.
            S_SHIFT_DN: raddr = AW'(idx_reg + CW'(drop_reg));
            S_SHIFT_DN_WR: begin
                we    = 1'b1;
                waddr = idx_reg[AW-1:0];
                wdata = rd;
                idx_next = idx_reg + CW'(1);
            end
            S_DONE: begin
                if (func_reg == FUNC_ALLOC && st_reg == ST_OK) begin
                    we    = 1'b1;
                    waddr = hit_reg[AW-1:0];
                    wdata = cur_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= CW'(1);
            init_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            rd_zero_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rd_zero_reg <= (raddr == '0);
            if (we && waddr == '0) begin
                init_reg <= 1'b0;
            end
            // Load the result once the output register is free.
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {2'b00, len_reg, off_reg, st_reg};
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
        cur_reg    <= cur_next;
        tmp_reg    <= tmp_next;
        drop_reg   <= drop_next;
        st_reg     <= st_next;
        off_reg    <= off_next;
        len_reg    <= len_next;
        merged_reg <= merged_next;
        if (accept) begin
            func_reg <= s_tuser;
            task_reg <= s_tdata[7:0];
            want_reg <= LW'(s_tdata[21:8]);
        end
    end
endmodule

/* rtl/ffa_checker.sv */
// Port-level checker for first_fit_allocator, bound to the top level.
// Depends on ffa_pkg.
module ffa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);
    import ffa_pkg::*;

    // One request in flight: input closes right after a transfer.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("input open after transfer");

    // Failing results carry zero offset and length.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[29:2] == '0))
        else $error("failed result has nonzero fields");

    // Status is one of the defined codes.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == ST_OK || m_tdata[1:0] == ST_NO_FIT
                      || m_tdata[1:0] == ST_NOT_FOUND)) else $error("bad status");

    // Result holds while stalled.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
endmodule

bind first_fit_allocator ffa_checker u_ffa_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

/* tb/tb.sv */
// Self-checking bench for the first-fit allocator: drives allocate and release
// transfers, predicts each result from a private segment table, compares.
// Depends on ffa_pkg and first_fit_allocator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ffa_pkg::*;

    localparam int MEM_BYTES = 16384;
    localparam int HDR_BYTES = 16;
    localparam int SEG_SLOTS = 32;

    typedef struct packed {
        func_t       func;
        logic [7:0]  task_id;
        logic [13:0] req_len;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic [13:0] offset;
        logic [13:0] length;
    } grant_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    first_fit_allocator u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 aclk = ~aclk;

    // Private copy of the segment table; lengths kept 32 bits wide.
    int unsigned seg_start[SEG_SLOTS];
    int unsigned seg_len[SEG_SLOTS];
    bit          seg_free[SEG_SLOTS];
    int unsigned seg_owner[SEG_SLOTS];
    int unsigned seg_count;

    request_t pending_reqs[$];
    grant_t   expected_grants[$];
    int       error_count = 0;
    bit       stim_done = 1'b0;

    function automatic void table_reset();
        seg_start[0] = 0;
        seg_len[0] = MEM_BYTES - HDR_BYTES;
        seg_free[0] = 1'b1;
        seg_owner[0] = 0;
        seg_count = 1;
    endfunction

    function automatic void drop_seg(int unsigned k);
        for (int unsigned j = k; j + 1 < seg_count; j++) begin
            seg_start[j] = seg_start[j+1];
            seg_len[j] = seg_len[j+1];
            seg_free[j] = seg_free[j+1];
            seg_owner[j] = seg_owner[j+1];
        end
        seg_count--;
    endfunction

    function automatic grant_t predict_grant(request_t r);
        grant_t g;
        int unsigned i, spare, off;
        g = '{ST_NO_FIT, 14'd0, 14'd0};
        if (r.func == FUNC_ALLOC) begin
            for (i = 0; i < seg_count; i++)
                if (seg_free[i] && seg_len[i] >= r.req_len) break;
            if (i >= seg_count) return g;
            spare = seg_len[i] - r.req_len;
            if (spare >= HDR_BYTES) begin
                if (seg_count >= SEG_SLOTS) return g;
                // open a slot above the chosen segment for the remainder
                for (int unsigned j = seg_count; j > i + 1; j--) begin
                    seg_start[j] = seg_start[j-1];
                    seg_len[j] = seg_len[j-1];
                    seg_free[j] = seg_free[j-1];
                    seg_owner[j] = seg_owner[j-1];
                end
                seg_count++;
                seg_start[i+1] = seg_start[i] + HDR_BYTES + r.req_len;
                seg_len[i+1] = spare - HDR_BYTES;
                seg_free[i+1] = 1'b1;
                seg_owner[i+1] = 0;
                seg_len[i] = r.req_len;
            end
            seg_free[i] = 1'b0;
            seg_owner[i] = r.task_id;
            g = '{ST_OK, 14'(seg_start[i] + HDR_BYTES), 14'(seg_len[i])};
        end else begin
            for (i = 0; i < seg_count; i++)
                if (!seg_free[i] && seg_owner[i] == r.task_id) break;
            if (i >= seg_count) begin
                g.status = ST_NOT_FOUND;
                return g;
            end
            off = seg_start[i] + HDR_BYTES;
            seg_free[i] = 1'b1;
            seg_owner[i] = 0;
            // merge with the next free neighbor, then the previous one
            if (i + 1 < seg_count && seg_free[i+1]) begin
                seg_len[i] += HDR_BYTES + seg_len[i+1];
                drop_seg(i + 1);
            end
            if (i > 0 && seg_free[i-1]) begin
                seg_len[i-1] += HDR_BYTES + seg_len[i];
                drop_seg(i);
                i--;
            end
            g = '{ST_OK, 14'(off), 14'(seg_len[i])};
        end
        return g;
    endfunction

    function automatic void push_req(func_t f, int unsigned t, int unsigned len);
        pending_reqs.push_back('{f, 8'(t), 14'(len)});
    endfunction

    // Mostly short gaps, now and then a long one, sometimes none at all.
    function automatic int unsigned pick_gap();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(3);
        return $urandom_range(40, 10);
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("tb: mismatch %s got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Input transfer seen at the last rising edge.
    bit in_fire = 1'b0;

    // Driver: present the head of the queue, advance on each transfer.
    int unsigned drv_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_fire) begin
                void'(pending_reqs.pop_front());
                drv_gap = pick_gap();
            end
            if (!s_tvalid || in_fire) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_reqs[0].func;
                    s_tdata  <= {2'b00, pending_reqs[0].req_len, pending_reqs[0].task_id};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Back-pressure on the result side.
    int unsigned rdy_gap = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (rdy_gap > 0) begin
                rdy_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(9) == 0) rdy_gap = pick_gap();
            end
        end
    end

    // Monitor: predict on input transfers, check on output transfers.
    always @(posedge aclk) begin
        grant_t got, want;
        in_fire = aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_grants.push_back(predict_grant('{func_t'(s_tuser),
                    s_tdata[7:0], s_tdata[21:8]}));
            if (m_tvalid && m_tready) begin
                got = '{status_t'(m_tdata[1:0]), m_tdata[15:2], m_tdata[29:16]};
                if (expected_grants.size() == 0) begin
                    report_mismatch("unexpected result, status", got.status, 0);
                end else begin
                    want = expected_grants.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.offset != want.offset)
                        report_mismatch("data_offset", got.offset, want.offset);
                    if (got.length != want.length)
                        report_mismatch("granted_length", got.length, want.length);
                end
            end
        end
    end

    initial begin
        int unsigned live_tasks[$];
        int unsigned t, len;
        table_reset();
        // Directed: extremes, exact fits, zero length, small remainder,
        // unknown task, table full, merges on both sides.
        push_req(FUNC_RELEASE, 8'd7, 0);               // unknown task
        push_req(FUNC_ALLOC, 8'd255, 16383);           // too large
        push_req(FUNC_ALLOC, 8'd0, 0);                 // zero length
        push_req(FUNC_ALLOC, 8'd1, 100);
        push_req(FUNC_ALLOC, 8'd2, 200);
        push_req(FUNC_ALLOC, 8'd3, 300);
        push_req(FUNC_RELEASE, 8'd1, 14'h3FFF);        // free with no free neighbor
        push_req(FUNC_RELEASE, 8'd3, 0);               // merges with the tail
        push_req(FUNC_RELEASE, 8'd2, 0);               // merges on both sides
        push_req(FUNC_ALLOC, 8'd4, 100);
        push_req(FUNC_ALLOC, 8'd5, 90);
        push_req(FUNC_RELEASE, 8'd4, 0);
        push_req(FUNC_ALLOC, 8'd6, 90);                // remainder below one header
        push_req(FUNC_RELEASE, 8'd0, 0);
        push_req(FUNC_RELEASE, 8'd6, 0);
        push_req(FUNC_RELEASE, 8'd5, 0);
        push_req(FUNC_ALLOC, 8'd170, MEM_BYTES - HDR_BYTES); // whole region
        push_req(FUNC_RELEASE, 8'd170, 0);
        for (int k = 0; k < 33; k++)                    // fill the table
            push_req(FUNC_ALLOC, 8'(k + 64), 8);
        for (int k = 0; k < 33; k++)
            push_req(FUNC_RELEASE, 8'(k + 64), 0);
        // Random: alloc/release mix on a small task pool, some noise.
        for (int n = 0; n < 1500; n++) begin
            case ($urandom_range(9))
                0: push_req(func_t'($urandom_range(1)), $urandom_range(255),
                            $urandom_range(16383));
                1, 2, 3, 4, 5: begin
                    t = $urandom_range(31) | ($urandom_range(1) << 7);
                    len = ($urandom_range(4) == 0) ? $urandom_range(16383)
                                                   : $urandom_range(1200);
                    push_req(FUNC_ALLOC, t, len);
                    live_tasks.push_back(t);
                end
                default: begin
                    if (live_tasks.size() > 0) begin
                        t = $urandom_range(live_tasks.size() - 1);
                        push_req(FUNC_RELEASE, live_tasks[t], $urandom_range(16383));
                        live_tasks.delete(t);
                    end else begin
                        push_req(FUNC_RELEASE, $urandom_range(255), 0);
                    end
                end
            endcase
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        wait (pending_reqs.size() == 0 && !s_tvalid);
        wait (expected_grants.size() == 0);
        repeat (200) @(posedge aclk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: the limit covers the worst case per item plus gaps on both sides.
    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule

/* filelist.f */
rtl/ffa_pkg.sv
rtl/ffa_seg_ram.sv
rtl/first_fit_allocator.sv
rtl/ffa_checker.sv
tb/tb.sv
